[rtl/core/spsq_pkg.sv]
// ----------------------------------------------------------------------------
// Stable sorted priority queue package
// Shared types and codes for the sorted queue cells and the top level.
// ----------------------------------------------------------------------------
package spsq_pkg;

    localparam int VALUE_W    = 32;
    localparam int PRIORITY_W = 16;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 5;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0]    value;
        logic [PRIORITY_W-1:0] prio;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t item;
    } cell_cmd_t;

endpackage

[rtl/core/spsq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted queue cell
// Holds one entry and shifts toward the tail on insert or toward the head on pop.
// ----------------------------------------------------------------------------
module spsq_cell (
    input  logic               aclk,
    input  spsq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_after,
    input  spsq_pkg::entry_t   left_entry,
    input  spsq_pkg::entry_t   right_entry,
    output logic               after,
    output spsq_pkg::entry_t   entry
);

    spsq_pkg::entry_t entry_reg;
    spsq_pkg::entry_t entry_next;

    // A cell lies after the insertion point when it is empty or holds a
    // strictly larger priority number; this flag is monotonic along the row.
    assign after = !occupied || (entry_reg.prio > cmd.item.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.push) begin
            if (after && !left_after) begin
                entry_next = cmd.item;
            end else if (after) begin
                entry_next = left_entry;
            end
        end else if (cmd.pop) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[rtl/core/stable_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// Stable sorted priority queue
// Bounded queue kept in priority order by a row of shift-insert cells.
// ----------------------------------------------------------------------------
//   Channel  Direction  tdata                                  tuser
//   s_       in         value[31:0] priority[47:32]            operation[0]
//   m_       out        value[31:0] priority[47:32] occ[52:48] status[1:0]
//
// Every cell compares its priority with the pushed one in the same cycle, so
// one word is accepted per cycle and its result is registered at that edge.
// The input is stalled only while a result waits and m_tready is low.
// Reset clears the entry count and the output valid; the cells need no clearing.
module stable_sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // item_value, item_priority
    input  logic [0:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // popped_value, popped_priority, occupancy
    output logic [1:0]  m_tuser    // status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                m_tvalid_reg;
    logic [55:0]         m_tdata_reg;
    logic [1:0]          m_tuser_reg;
    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic                op_pop;
    spsq_pkg::cell_cmd_t cmd;
    spsq_pkg::entry_t    cells [CAPACITY];
    logic [CAPACITY-1:0] after_vec;
    logic [CAPACITY-1:0] occ_vec;
    logic [CNT_W+4:0]    occ_ext;
    logic [55:0]         result_data;
    logic [1:0]          result_status;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign op_pop   = (s_tuser[0] == spsq_pkg::OP_POP);
    assign is_full  = (count_reg >= CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    assign cmd.push       = accept && !op_pop && !is_full;
    assign cmd.pop        = accept && op_pop && !is_empty;
    assign cmd.item.value = s_tdata[31:0];
    assign cmd.item.prio  = s_tdata[47:32];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            spsq_pkg::entry_t left_e;
            spsq_pkg::entry_t right_e;
            logic             left_a;

            assign occ_vec[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_head
                assign left_a = 1'b0;
                assign left_e = cmd.item;
            end else begin : g_body
                assign left_a = after_vec[gi-1];
                assign left_e = cells[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign right_e = cells[gi];
            end else begin : g_inner
                assign right_e = cells[gi+1];
            end

            spsq_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (occ_vec[gi]),
                .left_after  (left_a),
                .left_entry  (left_e),
                .right_entry (right_e),
                .after       (after_vec[gi]),
                .entry       (cells[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign occ_ext = {5'b0, count_next};

    always_comb begin
        result_data   = '0;
        result_status = spsq_pkg::ST_OK;
        if (op_pop) begin
            if (is_empty) begin
                result_status = spsq_pkg::ST_EMPTY;
            end else begin
                result_data[31:0]  = cells[0].value;
                result_data[47:32] = cells[0].prio;
            end
        end else if (is_full) begin
            result_status = spsq_pkg::ST_FULL;
        end
        result_data[52:48] = occ_ext[4:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_tdata_reg <= result_data;
            m_tuser_reg <= result_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_pop_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op_pop && is_empty) |=> (m_tuser == spsq_pkg::ST_EMPTY))
        else $error("pop on empty queue not reported");

    a_push_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !op_pop && !is_full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow the queue");

    a_pop_head : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op_pop && !is_empty) |=>
            (m_tdata[47:0] == {$past(cells[0].prio), $past(cells[0].value)}))
        else $error("pop did not return the head entry");

endmodule
